// ----- hw/rtl/triple_buffer_swap_chain_top_defines.svh -----
// assertion macros used by the swap chain checker
`ifndef TRIPLE_BUFFER_SWAP_CHAIN_TOP_DEFINES_SVH
`define TRIPLE_BUFFER_SWAP_CHAIN_TOP_DEFINES_SVH

// same-cycle implication, reset masks the check
`define TBSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swap chain check failed");

// next-cycle implication, reset masks the check
`define TBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swap chain check failed");

`endif

// ----- hw/rtl/tbsc_pkg.sv -----
// types, constants and codes of the triple buffer swap chain
package tbsc_pkg;

    localparam int NUM_SLOTS = 3;
    localparam int AGE_BITS  = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
    localparam int HANDLE_W  = 32;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    typedef enum logic [2:0] {
        REQ_ACQUIRE   = 3'd0,
        REQ_SWAP      = 3'd1,
        REQ_QUERY_AGE = 3'd2,
        REQ_LOCK      = 3'd3,
        REQ_RELEASE   = 3'd4,
        REQ_HAS_FREE  = 3'd5
    } req_code_t;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_NO_UNLOCK  = 3'd1,
        STS_ALLOC_FAIL = 3'd2,
        STS_NO_FRONT   = 3'd3,
        STS_NO_BACK    = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [HANDLE_W-1:0] buffer_handle;
        logic                alloc_ok;
    } req_t;

    typedef struct packed {
        logic [2:0]          status;
        logic [1:0]          slot_index;
        logic [HANDLE_W-1:0] handle_out;
        logic [7:0]          buffer_age;
        logic                free_available;
    } rsp_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic                present;
        logic                locked;
        logic [AGE_BITS-1:0] age;
    } slot_t;

    typedef struct packed {
        logic                en;
        logic [SLOT_W-1:0]   idx;
        logic                set_handle;
        logic [HANDLE_W-1:0] handle;
        logic                set_locked;
        logic                locked;
        logic                set_age;
        logic [AGE_BITS-1:0] age;
    } slot_wr_t;

    // age field as it leaves the block: low eight bits
    function automatic logic [7:0] age_out(input logic [AGE_BITS-1:0] age);
        logic [23:0] wide;
        wide = 24'(age);
        return wide[7:0];
    endfunction

endpackage

// ----- hw/rtl/tbsc_slot_bank.sv -----
// slot state registers with one read port and one write port
module tbsc_slot_bank (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [tbsc_pkg::SLOT_W-1:0]           rd_idx,
    input  tbsc_pkg::slot_wr_t                    wr,
    output tbsc_pkg::slot_t                       rd,
    output logic [tbsc_pkg::NUM_SLOTS-1:0]        locked_vec
);

    tbsc_pkg::slot_t slot_reg  [tbsc_pkg::NUM_SLOTS];
    tbsc_pkg::slot_t slot_next [tbsc_pkg::NUM_SLOTS];

    // apply the single write; acquiring a handle also marks the slot present
    always_comb
    begin
        for (int i = 0; i < tbsc_pkg::NUM_SLOTS; i++)
        begin
            slot_next[i] = slot_reg[i];
            if (wr.en && wr.idx == tbsc_pkg::SLOT_W'(i))
            begin
                if (wr.set_handle)
                begin
                    slot_next[i].handle  = wr.handle;
                    slot_next[i].present = 1'b1;
                end
                if (wr.set_locked)
                begin
                    slot_next[i].locked = wr.locked;
                end
                if (wr.set_age)
                begin
                    slot_next[i].age = wr.age;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tbsc_pkg::NUM_SLOTS; i++)
            begin
                slot_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < tbsc_pkg::NUM_SLOTS; i++)
            begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    // read port and lock summary
    assign rd = slot_reg[rd_idx];

    always_comb
    begin
        for (int i = 0; i < tbsc_pkg::NUM_SLOTS; i++)
        begin
            locked_vec[i] = slot_reg[i].locked;
        end
    end

endmodule

// ----- hw/rtl/triple_buffer_swap_chain_top.sv -----
// top level of the triple buffer swap chain with buffer age
//
// Usage: one request word enters on req (req_valid/req_ready) and exactly
// one response word leaves on rsp (rsp_valid/rsp_ready). Requests are
// acquire back, swap, query age, lock front, release and has free.
// Lock, has free, unused codes, swap without a back buffer and acquire or
// query when a back buffer is already held go from IDLE straight to APPLY;
// acquire or query without a back buffer, swap and release first pass SCAN,
// which walks the slots one per cycle through a single slot read port,
// compare and age-increment path. APPLY writes the response register.
// A request is taken only when the last one has left APPLY; req_ready is high
// only while the sequencer is idle.
// The response sits in an output register, so a new request may be taken
// while the previous response waits. If the receiver stalls, the next
// request finishes its slot walk and then waits before its final update.
// Reset clears all slots, ages and back/front pointers and empties the
// output register.
module triple_buffer_swap_chain_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  tbsc_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output tbsc_pkg::rsp_t  rsp
);

    tbsc_pkg::state_t                    state_reg, state_next;
    logic [2:0]                          req_type_reg, req_type_next;
    logic [tbsc_pkg::HANDLE_W-1:0]       handle_reg, handle_next;
    logic                                ok_reg, ok_next;
    logic [tbsc_pkg::SLOT_W-1:0]         scan_reg, scan_next;
    logic [tbsc_pkg::SLOT_W-1:0]         sel_reg, sel_next;
    logic                                found_reg, found_next;
    logic                                back_valid_reg, back_valid_next;
    logic [tbsc_pkg::SLOT_W-1:0]         back_slot_reg, back_slot_next;
    logic                                front_valid_reg, front_valid_next;
    logic [tbsc_pkg::SLOT_W-1:0]         front_slot_reg, front_slot_next;
    logic                                rsp_valid_reg, rsp_valid_next;
    tbsc_pkg::rsp_t                      rsp_reg, rsp_next;

    logic [tbsc_pkg::SLOT_W-1:0]         rd_idx;
    tbsc_pkg::slot_t                     rd;
    tbsc_pkg::slot_wr_t                  wr;
    logic [tbsc_pkg::NUM_SLOTS-1:0]      locked_vec;
    logic [tbsc_pkg::NUM_SLOTS-1:0]      lock_mask;

    logic accept, out_free, scan_last, is_acq, need_scan, lock_now;

    tbsc_slot_bank u_bank (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_idx     (rd_idx),
        .wr         (wr),
        .rd         (rd),
        .locked_vec (locked_vec)
    );

    // handshake and request decode
    assign req_ready = (state_reg == tbsc_pkg::ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign scan_last = (scan_reg == tbsc_pkg::SLOT_W'(tbsc_pkg::NUM_SLOTS - 1));
    assign is_acq    = (req_type_reg == tbsc_pkg::REQ_ACQUIRE) ||
                       (req_type_reg == tbsc_pkg::REQ_QUERY_AGE);
    assign lock_now  = (req_type_reg == tbsc_pkg::REQ_LOCK) && front_valid_reg;

    always_comb
    begin
        need_scan = 1'b0;
        if (req.req_type == tbsc_pkg::REQ_ACQUIRE || req.req_type == tbsc_pkg::REQ_QUERY_AGE)
        begin
            need_scan = !back_valid_reg;
        end
        else if (req.req_type == tbsc_pkg::REQ_SWAP)
        begin
            need_scan = back_valid_reg;
        end
        else if (req.req_type == tbsc_pkg::REQ_RELEASE)
        begin
            need_scan = 1'b1;
        end
    end

    // slot read address: walk counter, or the slot the final step works on
    always_comb
    begin
        if (state_reg == tbsc_pkg::ST_SCAN)
        begin
            rd_idx = scan_reg;
        end
        else if (req_type_reg == tbsc_pkg::REQ_LOCK)
        begin
            rd_idx = front_slot_reg;
        end
        else
        begin
            rd_idx = sel_reg;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tbsc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = need_scan ? tbsc_pkg::ST_SCAN : tbsc_pkg::ST_APPLY;
                end
            end
            tbsc_pkg::ST_SCAN:
            begin
                if (scan_last || (is_acq && !rd.locked))
                begin
                    state_next = tbsc_pkg::ST_APPLY;
                end
            end
            tbsc_pkg::ST_APPLY:
            begin
                if (out_free)
                begin
                    state_next = tbsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tbsc_pkg::ST_IDLE;
            end
        endcase
    end

    // the slot that a lock in this step makes locked
    always_comb
    begin
        for (int i = 0; i < tbsc_pkg::NUM_SLOTS; i++)
        begin
            lock_mask[i] = lock_now && (front_slot_reg == tbsc_pkg::SLOT_W'(i));
        end
    end

    // datapath, slot writes and response word
    always_comb
    begin
        req_type_next    = req_type_reg;
        handle_next      = handle_reg;
        ok_next          = ok_reg;
        scan_next        = scan_reg;
        sel_next         = sel_reg;
        found_next       = found_reg;
        back_valid_next  = back_valid_reg;
        back_slot_next   = back_slot_reg;
        front_valid_next = front_valid_reg;
        front_slot_next  = front_slot_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp_ready;
        rsp_next         = rsp_reg;
        wr               = '0;

        unique case (state_reg)
            tbsc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_type_next = req.req_type;
                    handle_next   = req.buffer_handle;
                    ok_next       = req.alloc_ok;
                    scan_next     = '0;
                    found_next    = back_valid_reg;
                    sel_next      = back_slot_reg;
                end
            end
            tbsc_pkg::ST_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                wr.idx    = scan_reg;
                if (is_acq)
                begin
                    // first unlocked slot becomes the back candidate
                    if (!rd.locked)
                    begin
                        found_next = 1'b1;
                        sel_next   = scan_reg;
                    end
                end
                else if (req_type_reg == tbsc_pkg::REQ_SWAP)
                begin
                    // age every live slot, the presented one restarts at one
                    wr.en      = 1'b1;
                    wr.set_age = 1'b1;
                    if (scan_reg == back_slot_reg)
                    begin
                        wr.age = tbsc_pkg::AGE_BITS'(1);
                    end
                    else if (rd.age != '0 && rd.age != tbsc_pkg::AGE_MAX)
                    begin
                        wr.age = rd.age + 1'b1;
                    end
                    else
                    begin
                        wr.age = rd.age;
                    end
                end
                else
                begin
                    // release by handle
                    wr.en         = rd.present && (rd.handle == handle_reg);
                    wr.set_locked = 1'b1;
                    wr.locked     = 1'b0;
                end
            end
            tbsc_pkg::ST_APPLY:
            begin
                if (out_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    rsp_next.free_available = |(~locked_vec & ~lock_mask);
                    if (is_acq)
                    begin
                        if (!found_reg)
                        begin
                            back_valid_next = 1'b0;
                            rsp_next.status = tbsc_pkg::STS_NO_UNLOCK;
                        end
                        else if (!rd.present && !ok_reg)
                        begin
                            back_valid_next = 1'b0;
                            rsp_next.status = tbsc_pkg::STS_ALLOC_FAIL;
                        end
                        else
                        begin
                            back_valid_next     = 1'b1;
                            back_slot_next      = sel_reg;
                            rsp_next.status     = tbsc_pkg::STS_OK;
                            rsp_next.slot_index = 2'(sel_reg);
                            rsp_next.buffer_age = tbsc_pkg::age_out(rd.age);
                            if (rd.present)
                            begin
                                rsp_next.handle_out = rd.handle;
                            end
                            else
                            begin
                                rsp_next.handle_out = handle_reg;
                                wr.en         = 1'b1;
                                wr.idx        = sel_reg;
                                wr.set_handle = 1'b1;
                                wr.handle     = handle_reg;
                            end
                        end
                    end
                    else if (req_type_reg == tbsc_pkg::REQ_SWAP)
                    begin
                        if (!back_valid_reg)
                        begin
                            rsp_next.status = tbsc_pkg::STS_NO_BACK;
                        end
                        else
                        begin
                            front_valid_next    = 1'b1;
                            front_slot_next     = back_slot_reg;
                            back_valid_next     = 1'b0;
                            rsp_next.slot_index = 2'(back_slot_reg);
                        end
                    end
                    else if (req_type_reg == tbsc_pkg::REQ_LOCK)
                    begin
                        if (!front_valid_reg)
                        begin
                            rsp_next.status = tbsc_pkg::STS_NO_FRONT;
                        end
                        else
                        begin
                            rsp_next.slot_index = 2'(front_slot_reg);
                            rsp_next.handle_out = rd.handle;
                            front_valid_next    = 1'b0;
                            wr.en         = 1'b1;
                            wr.idx        = front_slot_reg;
                            wr.set_locked = 1'b1;
                            wr.locked     = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tbsc_pkg::ST_IDLE;
            scan_reg        <= '0;
            sel_reg         <= '0;
            found_reg       <= 1'b0;
            back_valid_reg  <= 1'b0;
            back_slot_reg   <= '0;
            front_valid_reg <= 1'b0;
            front_slot_reg  <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_reg        <= scan_next;
            sel_reg         <= sel_next;
            found_reg       <= found_next;
            back_valid_reg  <= back_valid_next;
            back_slot_reg   <= back_slot_next;
            front_valid_reg <= front_valid_next;
            front_slot_reg  <= front_slot_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        req_type_reg <= req_type_next;
        handle_reg   <= handle_next;
        ok_reg       <= ok_next;
        rsp_reg      <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- hw/rtl/tbsc_checker.sv -----
// port-level checks of the swap chain, bound to the top level
`include "triple_buffer_swap_chain_top_defines.svh"

module tbsc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            req_valid,
    input logic            req_ready,
    input tbsc_pkg::req_t  req,
    input logic            rsp_valid,
    input logic            rsp_ready,
    input tbsc_pkg::rsp_t  rsp
);

    // a taken request drops req_ready in the following cycle
    `TBSC_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, req_valid && req_ready, !req_ready)

    // failed requests carry no handle and no age
    `TBSC_ASSERT_NOW(a_fail_clears_fields, clk, rst_n, rsp_valid && rsp.status != tbsc_pkg::STS_OK, rsp.handle_out == '0 && rsp.buffer_age == '0)

    // status and slot stay within their codes
    `TBSC_ASSERT_NOW(a_rsp_ranges, clk, rst_n, rsp_valid, rsp.status <= tbsc_pkg::STS_NO_BACK && 32'(rsp.slot_index) < tbsc_pkg::NUM_SLOTS)

    // a stalled response word holds
    `TBSC_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

endmodule

bind triple_buffer_swap_chain_top tbsc_checker u_tbsc_checker (.*);
